>>> src/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants of the postfix evaluator
// Token codes, status codes, the decoded command kind and the mul/div request.
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

  // Token characters
  localparam logic [7:0] TOK_ADD  = 8'h2B;  // '+'
  localparam logic [7:0] TOK_SUB  = 8'h2D;  // '-'
  localparam logic [7:0] TOK_MUL  = 8'h2A;  // '*'
  localparam logic [7:0] TOK_DIV  = 8'h2F;  // '/'
  localparam logic [7:0] TOK_END  = 8'h2E;  // '.'
  localparam logic [7:0] TOK_VAR0 = 8'h61;  // 'a'

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Fixed field widths
  localparam int unsigned TOKEN_W   = 8;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned TOP_W     = 32;
  localparam int unsigned DEPTH_W   = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_END
  } kind_e;

  localparam int unsigned KIND_W = $bits(kind_e);

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic start;
    logic div;
  } md_cmd_t;

endpackage

`default_nettype wire

>>> src/pfe_front.sv
// ----------------------------------------------------------------------------
// pfe_front: token decode
// Holds the variable registers, classifies each token and resolves the
// value a push token carries.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_front #(
  parameter int unsigned NUM_VARS   = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pfe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pfe_pkg::REG_W-1:0]       cfg_wdata_i,
  input  wire logic [pfe_pkg::TOKEN_W-1:0]     token_i,
  output pfe_pkg::kind_e                       kind_o,
  output logic [DATA_WIDTH-1:0]                value_o
);
  import pfe_pkg::*;

  localparam int unsigned VIW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  logic [REG_W-1:0]   var_q [NUM_VARS];
  logic [TOKEN_W-1:0] var_off;
  logic               is_var;
  logic [63:0]        var_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VARS; i++) begin
        var_q[i] <= '0;
      end
    end else if (cfg_we_i && (int'(cfg_idx_i) < NUM_VARS)) begin
      var_q[cfg_idx_i[VIW-1:0]] <= cfg_wdata_i;
    end
  end

  assign var_off = token_i - TOK_VAR0;
  assign is_var  = (token_i >= TOK_VAR0) && (int'(var_off) < NUM_VARS);
  assign var_ext = 64'(signed'(var_q[var_off[VIW-1:0]]));

  always_comb begin
    value_o = '0;
    priority if (token_i == TOK_ADD) begin
      kind_o = KIND_ADD;
    end else if (token_i == TOK_SUB) begin
      kind_o = KIND_SUB;
    end else if (token_i == TOK_MUL) begin
      kind_o = KIND_MUL;
    end else if (token_i == TOK_DIV) begin
      kind_o = KIND_DIV;
    end else if (token_i == TOK_END) begin
      kind_o = KIND_END;
    end else begin
      kind_o = KIND_PUSH;
      if (is_var) value_o = var_ext[DATA_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/pfe_fifo.sv
// ----------------------------------------------------------------------------
// pfe_fifo: two-entry command queue
// Decouples token decode from stack execution.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_fifo #(
  parameter int unsigned WIDTH = 35
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

>>> src/pfe_muldiv.sv
// ----------------------------------------------------------------------------
// pfe_muldiv: bit-serial multiply / signed divide
// One bit per cycle: shift-add multiply (low half) or restoring division on
// magnitudes with the sign applied at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_muldiv #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pfe_pkg::md_cmd_t      cmd_i,
  input  wire logic [DATA_WIDTH-1:0] a_i,
  input  wire logic [DATA_WIDTH-1:0] b_i,
  output logic                       done_o,
  output logic [DATA_WIDTH-1:0]      result_o
);
  import pfe_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned CNTW = $clog2(W + 1);

  logic            busy_q, done_q, div_q, neg_q;
  logic [CNTW-1:0] cnt_q;
  logic [W-1:0]    acc_q;  // product, or partial remainder
  logic [W-1:0]    opa_q;  // shifted multiplicand, or divisor magnitude
  logic [W-1:0]    opb_q;  // multiplier, or dividend shifting into quotient
  logic [W:0]      shifted;
  logic [W+1:0]    diff;

  assign shifted = {acc_q, opb_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, opa_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !cmd_i.start && busy_q && (cnt_q == CNTW'(1));
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      div_q <= cmd_i.div;
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
      if (cmd_i.div) begin
        opb_q <= a_i[W-1] ? (W'(0) - a_i) : a_i;
        opa_q <= b_i[W-1] ? (W'(0) - b_i) : b_i;
      end else begin
        opb_q <= b_i;
        opa_q <= a_i;
      end
    end else if (busy_q) begin
      if (div_q) begin
        if (!diff[W+1]) begin
          acc_q <= diff[W-1:0];
          opb_q <= {opb_q[W-2:0], 1'b1};
        end else begin
          acc_q <= shifted[W-1:0];
          opb_q <= {opb_q[W-2:0], 1'b0};
        end
      end else begin
        if (opb_q[0]) acc_q <= acc_q + opa_q;
        opa_q <= {opa_q[W-2:0], 1'b0};
        opb_q <= {1'b0, opb_q[W-1:1]};
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = !div_q ? acc_q : (neg_q ? (W'(0) - opb_q) : opb_q);

endmodule

`default_nettype wire

>>> src/pfe_back.sv
// ----------------------------------------------------------------------------
// pfe_back: stack execution
// Top of stack lives in a register, the rest in a single-port-style memory.
// Runs one command at a time and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfe_back #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire pfe_pkg::kind_e                q_kind_i,
  input  wire logic [DATA_WIDTH-1:0]         q_value_i,
  output logic                               q_pop_o,
  output pfe_pkg::md_cmd_t                   md_cmd_o,
  output logic [DATA_WIDTH-1:0]              md_a_o,
  output logic [DATA_WIDTH-1:0]              md_b_o,
  input  wire logic                          md_done_i,
  input  wire logic [DATA_WIDTH-1:0]         md_result_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pfe_pkg::TOP_W-1:0]          top_value_o,
  output logic [pfe_pkg::DEPTH_W-1:0]        depth_o,
  output logic [pfe_pkg::STATUS_W-1:0]       status_o,
  output logic                               expr_done_o
);
  import pfe_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_CALC,
    S_WAIT,
    S_RESP
  } state_e;

  state_e              state_q;
  kind_e               kind_q;
  logic [W-1:0]        cmd_val_q;
  logic [CW-1:0]       count_q;
  logic [W-1:0]        tos_q;
  logic [W-1:0]        second_q;
  logic [W-1:0]        res_top_q;
  logic [STATUS_W-1:0] res_status_q;
  logic                res_done_q;
  logic                out_valid_q;
  logic [TOP_W-1:0]    top_value_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [STATUS_W-1:0] status_q;
  logic                expr_done_q;

  // memory holds the entries below the top, index 0 at the bottom
  logic [W-1:0]  stack_mem [STACK_DEPTH];
  logic          mem_we, mem_re;
  logic [CW-1:0] cnt_m1, cnt_m2;
  logic [W-1:0]  sum, dif;
  logic [63:0]   top_ext;
  logic          is_full, slot_free, resp_fire;

  assign cnt_m1    = count_q - CW'(1);
  assign cnt_m2    = count_q - CW'(2);
  assign is_full   = (count_q == CW'(STACK_DEPTH));
  assign sum       = second_q + tos_q;
  assign dif       = second_q - tos_q;
  assign top_ext   = 64'(signed'(res_top_q));
  assign slot_free = !out_valid_q || !out_stall_i;
  assign resp_fire = (state_q == S_RESP) && slot_free;

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_comb begin
    mem_we = (state_q == S_DISPATCH) && (kind_q == KIND_PUSH) && !is_full
             && (count_q != '0);
    mem_re = (state_q == S_DISPATCH) && (kind_q != KIND_PUSH) && (kind_q != KIND_END)
             && (count_q >= CW'(2));
    md_cmd_o.start = (state_q == S_CALC)
                     && ((kind_q == KIND_MUL) || ((kind_q == KIND_DIV) && (tos_q != '0)));
    md_cmd_o.div   = (kind_q == KIND_DIV);
    md_a_o         = second_q;
    md_b_o         = tos_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[cnt_m1[AW-1:0]] <= tos_q;
    if (mem_re) second_q <= stack_mem[cnt_m2[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= KIND_PUSH;
      cmd_val_q    <= '0;
      count_q      <= '0;
      tos_q        <= '0;
      res_top_q    <= '0;
      res_status_q <= ST_OK;
      res_done_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      top_value_q  <= '0;
      depth_q      <= '0;
      status_q     <= ST_OK;
      expr_done_q  <= 1'b0;
    end else begin
      if (resp_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            kind_q    <= q_kind_i;
            cmd_val_q <= q_value_i;
            state_q   <= S_DISPATCH;
          end
        end

        S_DISPATCH: begin
          unique case (kind_q)
            KIND_PUSH: begin
              res_done_q <= 1'b0;
              state_q    <= S_RESP;
              if (is_full) begin
                res_status_q <= ST_OVER;
                res_top_q    <= tos_q;
              end else begin
                res_status_q <= ST_OK;
                tos_q        <= cmd_val_q;
                count_q      <= count_q + CW'(1);
                res_top_q    <= cmd_val_q;
              end
            end
            KIND_END: begin
              res_done_q <= 1'b1;
              state_q    <= S_RESP;
              if (count_q == '0) begin
                res_status_q <= ST_UNDER;
                res_top_q    <= '0;
              end else begin
                res_status_q <= ST_OK;
                res_top_q    <= tos_q;
                count_q      <= '0;
              end
            end
            default: begin
              res_done_q <= 1'b0;
              if (count_q < CW'(2)) begin
                res_status_q <= ST_UNDER;
                res_top_q    <= (count_q == '0) ? '0 : tos_q;
                state_q      <= S_RESP;
              end else begin
                res_status_q <= ST_OK;
                state_q      <= S_CALC;
              end
            end
          endcase
        end

        S_CALC: begin
          unique case (kind_q)
            KIND_ADD: begin
              tos_q     <= sum;
              res_top_q <= sum;
              count_q   <= cnt_m1;
              state_q   <= S_RESP;
            end
            KIND_SUB: begin
              tos_q     <= dif;
              res_top_q <= dif;
              count_q   <= cnt_m1;
              state_q   <= S_RESP;
            end
            KIND_DIV: begin
              if (tos_q == '0) begin
                res_status_q <= ST_DIVZ;
                res_top_q    <= tos_q;
                state_q      <= S_RESP;
              end else begin
                state_q <= S_WAIT;
              end
            end
            default: state_q <= S_WAIT;
          endcase
        end

        S_WAIT: begin
          if (md_done_i) begin
            tos_q     <= md_result_i;
            res_top_q <= md_result_i;
            count_q   <= cnt_m1;
            state_q   <= S_RESP;
          end
        end

        S_RESP: begin
          if (slot_free) begin
            top_value_q <= top_ext[TOP_W-1:0];
            depth_q     <= DEPTH_W'(count_q);
            status_q    <= res_status_q;
            expr_done_q <= res_done_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = top_value_q;
  assign depth_o     = depth_q;
  assign status_o    = status_q;
  assign expr_done_o = expr_done_q;

endmodule

`default_nettype wire

>>> src/postfix_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_top: RPN integer expression evaluator
// Token decode, a two-entry command queue, stack execution and a serial
// multiply/divide unit.
// ----------------------------------------------------------------------------
// One ASCII token per request, one result per token. Letters 'a'.. push the
// variable registers, other plain characters push 0, + - * / combine the top
// two values, '.' reports the final value and empties the stack. Errors
// (underflow, overflow, divide by zero) leave the stack untouched. A push or
// '.' passes through dispatch and response; + and - add a calculate step, and
// * and / then wait on the bit-serial multiply/divide unit, which works one
// bit per cycle, unless an error ends them early. The queue takes up to two
// tokens ahead while a command executes. The user must write the variable
// registers only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_expression_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned NUM_VARS    = 8,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pfe_pkg::REG_W-1:0]      cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pfe_pkg::TOKEN_W-1:0]    token_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [pfe_pkg::TOP_W-1:0]           top_value_o,
  output logic [pfe_pkg::DEPTH_W-1:0]         depth_o,
  output logic [pfe_pkg::STATUS_W-1:0]        status_o,
  output logic                                expr_done_o
);
  import pfe_pkg::*;

  localparam int unsigned QW = KIND_W + DATA_WIDTH;

  kind_e                 fe_kind;
  logic [DATA_WIDTH-1:0] fe_value;
  logic                  q_full, q_valid, q_pop;
  logic [QW-1:0]         q_data;
  kind_e                 q_kind;
  logic [DATA_WIDTH-1:0] q_value;
  md_cmd_t               md_cmd;
  logic [DATA_WIDTH-1:0] md_a, md_b, md_result;
  logic                  md_done;

  pfe_front #(
    .NUM_VARS   (NUM_VARS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .token_i     (token_i),
    .kind_o      (fe_kind),
    .value_o     (fe_value)
  );

  assign in_stall_o = q_full;

  pfe_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  ({fe_kind, fe_value}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  assign q_kind  = kind_e'(q_data[QW-1:DATA_WIDTH]);
  assign q_value = q_data[DATA_WIDTH-1:0];

  pfe_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_kind_i    (q_kind),
    .q_value_i   (q_value),
    .q_pop_o     (q_pop),
    .md_cmd_o    (md_cmd),
    .md_a_o      (md_a),
    .md_b_o      (md_b),
    .md_done_i   (md_done),
    .md_result_i (md_result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .top_value_o (top_value_o),
    .depth_o     (depth_o),
    .status_o    (status_o),
    .expr_done_o (expr_done_o)
  );

  pfe_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (md_cmd),
    .a_i      (md_a),
    .b_i      (md_b),
    .done_o   (md_done),
    .result_o (md_result)
  );

  // an accepted token is always waiting in the queue the next cycle
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_valid)
    else $error("accepted token missing from queue");

  // end of expression always leaves an empty stack
  a_end_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expr_done_o |-> depth_o == '0)
    else $error("stack not empty after end of expression");

  // divide by zero only comes from an operator token
  a_divz_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_DIVZ) |-> !expr_done_o && depth_o >= DEPTH_W'(2))
    else $error("divide-by-zero status on a bad token");

  // a mul/div start is never followed directly by another start
  a_md_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_cmd.start |=> !md_cmd.start)
    else $error("back-to-back mul/div start");

endmodule

`default_nettype wire
